>>> rtl/rdt_pkg.sv
// shared types and constants for the radio device tracker table
`timescale 1ns / 1ps
`default_nettype none

package rdt_pkg;

   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 6;
   localparam int ADDR_BITS = 48;
   localparam int MCAST_BIT = 40;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [31:0] WINDOW_RESET = 32'h0000_0001;

   typedef enum logic [1:0] {
      OP_OBSERVE = 2'd0,
      OP_WINDOW  = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_UPDATED   = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_MCAST     = 3'd3,
      ST_WINDOW    = 3'd4,
      ST_CLEARED   = 3'd5,
      ST_READ_OK   = 3'd6,
      ST_BAD_INDEX = 3'd7
   } status_type;

   typedef enum logic {
      KIND_WIFI = 1'b0,
      KIND_BLE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                  kind;
      logic [ADDR_BITS-1:0]  address;
      logic signed [7:0]     rssi;
      logic [7:0]            channel;
      logic [31:0]           first_seen;
      logic [31:0]           last_seen;
      logic [31:0]           last_window;
      logic [15:0]           observations;
      logic [15:0]           windows_seen;
   } entry_type;

   typedef struct packed {
      op_type                operation;
      logic                  device_kind;
      logic [ADDR_BITS-1:0]  device_address;
      logic signed [7:0]     signal_strength;
      logic [7:0]            radio_channel;
      logic [31:0]           time_ms;
      logic [INDEX_W-1:0]    read_index;
   } req_word_type;

   typedef struct packed {
      status_type            status;
      logic [INDEX_W-1:0]    entry_index;
      logic [COUNT_W-1:0]    entry_count;
      logic                  entry_kind;
      logic [ADDR_BITS-1:0]  entry_address;
      logic signed [7:0]     entry_rssi;
      logic [7:0]            entry_channel;
      logic [31:0]           entry_first_seen;
      logic [31:0]           entry_last_seen;
      logic [15:0]           entry_observations;
      logic [15:0]           entry_windows_seen;
   } rsp_word_type;

   typedef struct packed {
      logic       capture;
      logic       scan_start;
      logic       scan_next;
      logic       read_index;
      logic       load_hit;
      logic       load_read;
      logic       load_fresh;
      logic       commit;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type operation;
      logic   mcast;
      logic   ridx_ok;
      logic   count_zero;
      logic   count_full;
      logic   hit;
      logic   scan_last;
      logic   out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/rdt_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface rdt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic               device_kind;
   logic [47:0]        device_address;
   logic signed [7:0]  signal_strength;
   logic [7:0]         radio_channel;
   logic [31:0]        time_ms;
   logic [5:0]         read_index;

   modport source (output valid, operation, device_kind, device_address, signal_strength,
                   radio_channel, time_ms, read_index, input ready);
   modport sink (input valid, operation, device_kind, device_address, signal_strength,
                 radio_channel, time_ms, read_index, output ready);
endinterface

interface rdt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [5:0]         entry_index;
   logic [5:0]         entry_count;
   logic               entry_kind;
   logic [47:0]        entry_address;
   logic signed [7:0]  entry_rssi;
   logic [7:0]         entry_channel;
   logic [31:0]        entry_first_seen;
   logic [31:0]        entry_last_seen;
   logic [15:0]        entry_observations;
   logic [15:0]        entry_windows_seen;

   modport source (output valid, status, entry_index, entry_count, entry_kind,
                   entry_address, entry_rssi, entry_channel, entry_first_seen,
                   entry_last_seen, entry_observations, entry_windows_seen, input ready);
   modport sink (input valid, status, entry_index, entry_count, entry_kind,
                 entry_address, entry_rssi, entry_channel, entry_first_seen,
                 entry_last_seen, entry_observations, entry_windows_seen, output ready);
endinterface

`default_nettype wire

>>> rtl/radio_device_tracker_table_core.sv
// top level of the radio device tracker table
//
//   channel  dir  handshake      word
//   req_     in   valid/ready    operation, device key, rssi, channel, time, read index
//   rsp_     out  valid/ready    status, slot, count and slot contents
//
// window, clear and bad-index items go from accept through decode to commit, a read
// adds a read of the entry memory, and an observe may add a search of the stored entries
// (up to TABLE_DEPTH), one at a time through the single read port of the entry memory.
// reset is synchronous and needs no clearing pass; entries are written before use.
// the result register holds one word; a stalled rsp_ side holds the next item in commit.
`timescale 1ns / 1ps
`default_nettype none

module radio_device_tracker_table_core
   import rdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 48
) (
   input logic       clock,
   input logic       reset,
   rdt_req_if.sink   req,
   rdt_rsp_if.source rsp
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         ready;

   assign req.ready = ready;

   rdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire

>>> rtl/rdt_ctrl.sv
// controller state machine for the device tracker table
`timescale 1ns / 1ps
`default_nettype none

module rdt_ctrl
   import rdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_READ   = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_COMMIT;
            unique case (stat.operation)
               OP_WINDOW: status_in = ST_WINDOW;
               OP_CLEAR:  status_in = ST_CLEARED;
               OP_READ: begin
                  if (stat.ridx_ok) begin
                     cmd.read_index = 1'b1;
                     status_in      = ST_READ_OK;
                     state_in       = S_READ;
                  end else begin
                     status_in = ST_BAD_INDEX;
                  end
               end
               OP_OBSERVE: begin
                  if (stat.mcast) begin
                     status_in = ST_MCAST;
                  end else if (stat.count_zero) begin
                     cmd.load_fresh = 1'b1;
                     status_in      = ST_INSERTED;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: status_in = ST_WINDOW;
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.load_hit = 1'b1;
               status_in    = ST_UPDATED;
               state_in     = S_COMMIT;
            end else if (!stat.scan_last) begin
               cmd.scan_next = 1'b1;
            end else if (stat.count_full) begin
               status_in = ST_FULL;
               state_in  = S_COMMIT;
            end else begin
               cmd.load_fresh = 1'b1;
               status_in      = ST_INSERTED;
               state_in       = S_COMMIT;
            end
         end
         S_READ: begin
            cmd.load_read = 1'b1;
            state_in      = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_UPDATED;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted word did not move to decode");

   a_commit_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("commit did not return to idle");

endmodule

`default_nettype wire

>>> rtl/rdt_datapath.sv
// datapath: entry memory, search pointer, window counter and result register
`timescale 1ns / 1ps
`default_nettype none

module rdt_datapath
   import rdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 48
) (
   input  logic         clock,
   input  logic         reset,
   rdt_req_if.sink      req,
   rdt_rsp_if.source    rsp,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_DEPTH);

   req_word_type       req_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        window_ff, window_in;
   logic [INDEX_W-1:0] scan_ff, scan_in;
   logic [INDEX_W-1:0] slot_ff;
   entry_type          entry_ff;
   entry_type          rdata_ff;
   entry_type          mem_ff [TABLE_DEPTH];
   rsp_word_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic               rd_en;
   logic [INDEX_W-1:0] rd_idx;
   logic [INDEX_W-1:0] scan_inc;
   entry_type          fresh;
   entry_type          updated;
   logic               wr_en;
   logic               out_free;

   assign scan_inc = scan_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // read address select
   always_comb begin
      rd_en   = cmd.scan_start || cmd.scan_next || cmd.read_index;
      scan_in = scan_ff;
      rd_idx  = req_ff.read_index;
      if (cmd.scan_start) begin
         rd_idx  = '0;
         scan_in = '0;
      end else if (cmd.scan_next) begin
         rd_idx  = scan_inc;
         scan_in = scan_inc;
      end
   end

   always_comb begin
      fresh              = '0;
      fresh.kind         = req_ff.device_kind;
      fresh.address      = req_ff.device_address;
      fresh.first_seen   = req_ff.time_ms;
   end

   // observation update of the held entry
   always_comb begin
      updated           = entry_ff;
      updated.rssi      = req_ff.signal_strength;
      updated.channel   = req_ff.radio_channel;
      updated.last_seen = req_ff.time_ms;
      if (entry_ff.observations != COUNT_MAX) begin
         updated.observations = entry_ff.observations + 1'b1;
      end
      if (entry_ff.last_window != window_ff) begin
         updated.last_window = window_ff;
         if (entry_ff.windows_seen != COUNT_MAX) begin
            updated.windows_seen = entry_ff.windows_seen + 1'b1;
         end
      end
   end

   assign wr_en = cmd.commit && (cmd.status == ST_UPDATED || cmd.status == ST_INSERTED);

   always_comb begin
      count_in  = count_ff;
      window_in = window_ff;
      rsp_in    = '0;
      rsp_in.status = cmd.status;
      case (cmd.status)
         ST_UPDATED, ST_INSERTED: begin
            if (cmd.status == ST_INSERTED) begin
               count_in = count_ff + 1'b1;
            end
            rsp_in.entry_index        = slot_ff;
            rsp_in.entry_kind         = updated.kind;
            rsp_in.entry_address      = updated.address;
            rsp_in.entry_rssi         = updated.rssi;
            rsp_in.entry_channel      = updated.channel;
            rsp_in.entry_first_seen   = updated.first_seen;
            rsp_in.entry_last_seen    = updated.last_seen;
            rsp_in.entry_observations = updated.observations;
            rsp_in.entry_windows_seen = updated.windows_seen;
         end
         ST_READ_OK: begin
            rsp_in.entry_index        = slot_ff;
            rsp_in.entry_kind         = entry_ff.kind;
            rsp_in.entry_address      = entry_ff.address;
            rsp_in.entry_rssi         = entry_ff.rssi;
            rsp_in.entry_channel      = entry_ff.channel;
            rsp_in.entry_first_seen   = entry_ff.first_seen;
            rsp_in.entry_last_seen    = entry_ff.last_seen;
            rsp_in.entry_observations = entry_ff.observations;
            rsp_in.entry_windows_seen = entry_ff.windows_seen;
         end
         ST_BAD_INDEX: rsp_in.entry_index = req_ff.read_index;
         ST_WINDOW:    window_in = window_ff + 1'b1;
         ST_CLEARED: begin
            count_in  = '0;
            window_in = WINDOW_RESET;
         end
         default: rsp_in.entry_index = '0;
      endcase
      rsp_in.entry_count = count_in;
      if (!cmd.commit) begin
         count_in  = count_ff;
         window_in = window_ff;
      end
   end

   always_comb begin
      stat.operation  = req_ff.operation;
      stat.mcast      = (req_ff.device_kind == KIND_WIFI) && req_ff.device_address[MCAST_BIT];
      stat.ridx_ok    = req_ff.read_index < count_ff;
      stat.count_zero = count_ff == '0;
      stat.count_full = count_ff == DEPTH_CNT;
      stat.hit        = (rdata_ff.kind == req_ff.device_kind) &&
                        (rdata_ff.address == req_ff.device_address);
      stat.scan_last  = scan_inc == count_ff;
      stat.out_free   = out_free;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[slot_ff[ADDR_W-1:0]] <= updated;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_idx[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff.operation       <= op_type'(req.operation);
         req_ff.device_kind     <= req.device_kind;
         req_ff.device_address  <= req.device_address;
         req_ff.signal_strength <= req.signal_strength;
         req_ff.radio_channel   <= req.radio_channel;
         req_ff.time_ms         <= req.time_ms;
         req_ff.read_index      <= req.read_index;
      end
      scan_ff <= scan_in;
      if (cmd.load_hit) begin
         entry_ff <= rdata_ff;
         slot_ff  <= scan_ff;
      end else if (cmd.load_read) begin
         entry_ff <= rdata_ff;
         slot_ff  <= req_ff.read_index;
      end else if (cmd.load_fresh) begin
         entry_ff <= fresh;
         slot_ff  <= count_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         window_ff <= window_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.status             = rsp_ff.status;
   assign rsp.entry_index        = rsp_ff.entry_index;
   assign rsp.entry_count        = rsp_ff.entry_count;
   assign rsp.entry_kind         = rsp_ff.entry_kind;
   assign rsp.entry_address      = rsp_ff.entry_address;
   assign rsp.entry_rssi         = rsp_ff.entry_rssi;
   assign rsp.entry_channel      = rsp_ff.entry_channel;
   assign rsp.entry_first_seen   = rsp_ff.entry_first_seen;
   assign rsp.entry_last_seen    = rsp_ff.entry_last_seen;
   assign rsp.entry_observations = rsp_ff.entry_observations;
   assign rsp.entry_windows_seen = rsp_ff.entry_windows_seen;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("result word overwritten while still pending");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd.status == ST_INSERTED) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the entry count");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_next |-> (scan_inc < count_ff))
      else $error("search ran past the valid entries");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd.status == ST_INSERTED) |-> (count_ff < DEPTH_CNT))
      else $error("insert into a full table");

endmodule

`default_nettype wire
